// ===== hw/rtl/srtf_pkg.sv =====
// Shared types, constants and state codes for the shortest-remaining-time-first scheduler.
package srtf_pkg;

   // Field widths fixed by the item format.
   localparam int PnumWidth  = 5;
   localparam int TimeWidth  = 16;
   localparam int BurstWidth = 8;
   localparam int EntryWidth = TimeWidth + BurstWidth;

   // Default table size and reset value of the process count register.
   localparam int MaxProcessesDefault = 16;
   localparam logic [PnumWidth-1:0] CountReset = PnumWidth'(1);

   // Saturation value of the time counter.
   localparam logic [TimeWidth-1:0] TimeMax = '1;

   // Depth of the command queue between front and back.
   localparam int QueueDepth = 2;

   // Input action codes.
   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   // Command kinds after classification by the front.
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_WRITE
   } back_state_type;

   // One input word.
   typedef struct packed {
      action_type             action;
      logic [PnumWidth-1:0]   process_number;
      logic [TimeWidth-1:0]   arrival;
      logic [BurstWidth-1:0]  burst;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [TimeWidth-1:0]   tick_time;
      logic [PnumWidth-1:0]   running_process;
      logic                   finished;
      logic [TimeWidth-1:0]   completion_time;
      logic                   all_done;
   } rsp_type;

   // A classified command as held in the queue; slot is the zero-based entry.
   typedef struct packed {
      cmd_type                cmd;
      logic [PnumWidth-1:0]   slot;
      logic [TimeWidth-1:0]   arrival;
      logic [BurstWidth-1:0]  burst;
   } queue_entry_type;

   // Queue status and data seen by the back end.
   typedef struct packed {
      logic             valid;
      queue_entry_type  entry;
   } queue_out_type;

endpackage

// ===== hw/rtl/srtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srtf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(Depth)-1:0]  wr_addr,
   input  logic [Width-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]          rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/srtf_front.sv =====
// Front end: accepts command words, classifies them and queues them for the back end.
module srtf_front #(
   parameter int MaxProcesses = srtf_pkg::MaxProcessesDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  srtf_pkg::req_type        req_data,
   output logic                     busy,
   output srtf_pkg::queue_out_type  queue_out,
   input  logic                     queue_pop
);
   import srtf_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   queue_entry_type entries_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic            accept;
   logic            pnum_ok;
   logic            push;
   logic            pop;
   queue_entry_type new_entry;

   // Classify the incoming word; loads to a nonexistent entry are dropped here.
   always_comb begin
      accept  = start && !busy;
      pnum_ok = (req_data.process_number != '0) &&
                (32'(req_data.process_number) <= MaxProcesses);
      push    = accept && ((req_data.action == ACT_TICK) || pnum_ok);

      new_entry.cmd     = (req_data.action == ACT_TICK) ? CMD_TICK : CMD_LOAD;
      new_entry.slot    = req_data.process_number - PnumWidth'(1);
      new_entry.arrival = req_data.arrival;
      new_entry.burst   = req_data.burst;
   end

   // Queue pointers and fill level.
   always_comb begin
      pop       = queue_pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QueueDepth - 1) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QueueDepth - 1) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign busy            = (32'(count_ff) == QueueDepth);
   assign queue_out.valid = (count_ff != '0);
   assign queue_out.entry = entries_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/srtf_back.sv =====
// Back end: writes process entries and runs one scheduling scan per tick.
module srtf_back #(
   parameter int MaxProcesses = srtf_pkg::MaxProcessesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srtf_pkg::queue_out_type             queue_in,
   output logic                                queue_pop,
   input  logic [$clog2(MaxProcesses+1)-1:0]   used_count,
   output logic                                rsp_valid,
   output srtf_pkg::rsp_type                   rsp_data
);
   import srtf_pkg::*;

   localparam int IdxW = $clog2(MaxProcesses);
   localparam int CntW = $clog2(MaxProcesses + 1);

   back_state_type state_ff, state_in;

   // Scan control.
   logic [CntW-1:0]         issue_ff, issue_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IdxW-1:0]         rd_idx_ff, rd_idx_in;
   logic                    rd_bit_ff, rd_bit_in;

   // Running best candidate and count of entries with work left.
   logic                    found_ff, found_in;
   logic [IdxW-1:0]         best_idx_ff, best_idx_in;
   logic [BurstWidth-1:0]   best_rem_ff, best_rem_in;
   logic [TimeWidth-1:0]    best_arr_ff, best_arr_in;
   logic [CntW-1:0]         nz_ff, nz_in;

   logic [MaxProcesses-1:0] loaded_ff, loaded_in;
   logic [TimeWidth-1:0]    time_ff, time_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Table memory: arrival in the upper bits, remaining work in the lower bits.
   logic                    ram_we;
   logic [IdxW-1:0]         ram_waddr;
   logic [EntryWidth-1:0]   ram_wdata;
   logic                    ram_re;
   logic [IdxW-1:0]         ram_raddr;
   logic [EntryWidth-1:0]   ram_rdata;

   logic [BurstWidth-1:0]   ent_rem;
   logic [TimeWidth-1:0]    ent_arr;
   logic                    ent_better;
   logic                    fin;

   srtf_ram #(
      .Width (EntryWidth),
      .Depth (MaxProcesses)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (queue_in.valid && (queue_in.entry.cmd == CMD_TICK)) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if ((issue_ff >= used_count) && !rd_vld_ff) begin
               state_in = BK_WRITE;
            end
         end
         BK_WRITE: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Compare the entry whose read data has just arrived against the best so far.
   always_comb begin
      ent_rem    = rd_bit_ff ? ram_rdata[BurstWidth-1:0] : '0;
      ent_arr    = ram_rdata[EntryWidth-1:BurstWidth];
      ent_better = (ent_rem != '0) && (ent_arr <= time_ff) &&
                   (!found_ff || (ent_rem < best_rem_ff) ||
                    ((ent_rem == best_rem_ff) && (ent_arr < best_arr_ff)));
      fin        = found_ff && (best_rem_ff == BurstWidth'(1));
   end

   // Datapath and outputs per state.
   always_comb begin
      queue_pop    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = best_idx_ff;
      ram_wdata    = {best_arr_ff, best_rem_ff - BurstWidth'(1)};
      ram_re       = 1'b0;
      ram_raddr    = issue_ff[IdxW-1:0];
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rd_bit_in    = rd_bit_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_arr_in  = best_arr_ff;
      nz_in        = nz_ff;
      loaded_in    = loaded_ff;
      time_in      = time_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         BK_IDLE: begin
            queue_pop = queue_in.valid;
            issue_in  = '0;
            found_in  = 1'b0;
            nz_in     = '0;
            if (queue_in.valid && (queue_in.entry.cmd == CMD_LOAD)) begin
               ram_we    = 1'b1;
               ram_waddr = IdxW'(queue_in.entry.slot);
               ram_wdata = {queue_in.entry.arrival, queue_in.entry.burst};
               loaded_in[IdxW'(queue_in.entry.slot)] = 1'b1;
            end
         end
         BK_SCAN: begin
            // Issue one read per cycle over the entries in use.
            if (issue_ff < used_count) begin
               ram_re    = 1'b1;
               issue_in  = issue_ff + CntW'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IdxW-1:0];
               rd_bit_in = loaded_ff[issue_ff[IdxW-1:0]];
            end
            if (rd_vld_ff) begin
               if (ent_rem != '0) begin
                  nz_in = nz_ff + CntW'(1);
               end
               if (ent_better) begin
                  found_in    = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_rem_in = ent_rem;
                  best_arr_in = ent_arr;
               end
            end
         end
         BK_WRITE: begin
            // Run the chosen process one unit and report the slot.
            ram_we                      = found_ff;
            rsp_valid_in                = 1'b1;
            rsp_data_in.tick_time       = time_ff;
            rsp_data_in.running_process = found_ff ? PnumWidth'(32'(best_idx_ff) + 1) : '0;
            rsp_data_in.finished        = fin;
            rsp_data_in.completion_time = !fin ? '0 :
                                          (time_ff == TimeMax) ? TimeMax :
                                          time_ff + TimeWidth'(1);
            rsp_data_in.all_done        = (nz_ff == '0) || ((nz_ff == CntW'(1)) && fin);
            if (time_ff != TimeMax) begin
               time_in = time_ff + TimeWidth'(1);
            end
         end
         default: begin
            queue_pop = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         loaded_ff    <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         loaded_ff    <= loaded_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      rd_bit_ff   <= rd_bit_in;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_arr_ff <= best_arr_in;
      nz_ff       <= nz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/srtf_preemptive_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler: front, queue, back and CSR.
// A load word is written to the table from the idle state and produces no result.
// A tick word strobes its result after an idle check, one read per entry in use, a drain
// of the last read and a write-back. The back end pops no new word until that write-back;
// a two-word queue lets start be taken meanwhile.
// Results are never held off. Reset clears time, marks all entries unloaded, sets count to one.
module srtf_preemptive_scheduler #(
   parameter int MaxProcesses = srtf_pkg::MaxProcessesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  srtf_pkg::req_type                 req_data,
   output logic                              busy,
   output logic                              rsp_valid,
   output srtf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srtf_pkg::PnumWidth-1:0]    csr_data
);
   import srtf_pkg::*;

   localparam int CntW = $clog2(MaxProcesses + 1);

   logic [PnumWidth-1:0] count_ff, count_in;
   logic [CntW-1:0]      used_count;
   queue_out_type        queue_out;
   logic                 queue_pop;

   // Process count register; the write channel is always ready.
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountReset;
      end else begin
         count_ff <= count_in;
      end
   end

   // Counts beyond the table size act as the table size.
   always_comb begin
      if (32'(count_ff) > MaxProcesses) begin
         used_count = CntW'(MaxProcesses);
      end else begin
         used_count = CntW'(count_ff);
      end
   end

   srtf_front #(
      .MaxProcesses (MaxProcesses)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .queue_out (queue_out),
      .queue_pop (queue_pop)
   );

   srtf_back #(
      .MaxProcesses (MaxProcesses)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_in   (queue_out),
      .queue_pop  (queue_pop),
      .used_count (used_count),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // Every write-back is followed by the idle state, so result strobes never come back to back.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // A finished process always reports a nonzero completion time.
   a_fin_ctime: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished) |-> (rsp_data.completion_time != '0))
      else $error("finished slot without completion time");

   // If everything is done after a busy slot, the process that ran must have finished.
   a_done_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.all_done && (rsp_data.running_process != '0))
         |-> rsp_data.finished)
      else $error("all done while running process still has work");

   // The queue is only popped while it holds a word.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_out.valid)
      else $error("queue popped while empty");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the shortest-remaining-time-first scheduler.
`timescale 1ns / 100ps

module tb_top;
   import srtf_pkg::*;

   localparam int NumProc      = MaxProcessesDefault;
   localparam int SettleCycles = NumProc + 8;
   localparam int DrainCycles  = NumProc + 8;
   localparam int StallLimit   = 2000;
   localparam int PrintLimit   = 40;
   localparam int PhaseWords   = 200;
   localparam int NumPhases    = 10;

   // One pending operation: a scheduler word, or a write of the process count.
   typedef struct packed {
      logic                  is_cfg;
      logic                  gaps_ok;
      logic [PnumWidth-1:0]  count;
      req_type               word;
   } pending_op_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   req_type               req_data = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [PnumWidth-1:0]  csr_data = '0;

   srtf_preemptive_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Clock generation.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Operations waiting to be driven, and slot reports waiting to be seen.
   pending_op_type  word_backlog[$];
   rsp_type         due_reports[$];

   // Shadow scheduler state.
   logic [TimeWidth-1:0]   proc_arrival[NumProc];
   logic [BurstWidth-1:0]  proc_left[NumProc];
   logic [TimeWidth-1:0]   slot_now;
   logic [PnumWidth-1:0]   count_reg;

   // Stimulus-side bookkeeping.
   int    gen_time = 0;
   logic  gen_gaps = 1'b1;

   int    mismatches = 0;
   int    reports_checked = 0;
   int    words_sent = 0;
   int    cfg_writes = 0;
   int    idle_slots = 0;
   int    finish_slots = 0;

   // Apply one accepted word to the shadow state; a tick yields the slot report.
   task automatic schedule_word(input req_type w);
      int       best;
      int       n;
      int       i;
      rsp_type  rpt;
      if (w.action == ACT_LOAD) begin
         if (w.process_number >= 1 && w.process_number <= NumProc) begin
            proc_arrival[w.process_number - 1] = w.arrival;
            proc_left[w.process_number - 1] = w.burst;
         end
      end else begin
         n = (count_reg > NumProc) ? NumProc : int'(count_reg);
         best = -1;
         rpt = '0;
         rpt.tick_time = slot_now;
         // Least remaining work wins; ties go to earlier arrival, then lower number.
         for (i = 0; i < n; i++) begin
            if (proc_left[i] != 0 && proc_arrival[i] <= slot_now) begin
               if (best < 0 || proc_left[i] < proc_left[best] ||
                   (proc_left[i] == proc_left[best] &&
                    proc_arrival[i] < proc_arrival[best]))
                  best = i;
            end
         end
         if (best >= 0) begin
            proc_left[best] = proc_left[best] - 1'b1;
            rpt.running_process = PnumWidth'(best + 1);
            if (proc_left[best] == 0) begin
               rpt.finished = 1'b1;
               rpt.completion_time = (slot_now < TimeMax) ? slot_now + 1'b1 : TimeMax;
               finish_slots++;
            end
         end else begin
            idle_slots++;
         end
         rpt.all_done = 1'b1;
         for (i = 0; i < n; i++)
            if (proc_left[i] != 0)
               rpt.all_done = 1'b0;
         if (slot_now < TimeMax)
            slot_now = slot_now + 1'b1;
         due_reports = {due_reports, rpt};
      end
   endtask

   // Stimulus helpers.
   task automatic push_load(input logic [PnumWidth-1:0] pnum,
                            input logic [TimeWidth-1:0] arr,
                            input logic [BurstWidth-1:0] work);
      pending_op_type op;
      op = '0;
      op.gaps_ok = gen_gaps;
      op.word.action = ACT_LOAD;
      op.word.process_number = pnum;
      op.word.arrival = arr;
      op.word.burst = work;
      word_backlog = {word_backlog, op};
   endtask

   task automatic push_tick();
      pending_op_type op;
      op = '0;
      op.gaps_ok = gen_gaps;
      op.word.action = ACT_TICK;
      // The other fields are ignored on a tick; keep them moving anyway.
      op.word.process_number = PnumWidth'($urandom_range(0, 31));
      op.word.arrival = TimeWidth'($urandom_range(0, 65535));
      op.word.burst = BurstWidth'($urandom_range(0, 255));
      word_backlog = {word_backlog, op};
      if (gen_time < 65535)
         gen_time++;
   endtask

   task automatic push_cfg(input logic [PnumWidth-1:0] value);
      pending_op_type op;
      op = '0;
      op.is_cfg = 1'b1;
      op.gaps_ok = gen_gaps;
      op.count = value;
      word_backlog = {word_backlog, op};
   endtask

   // Mostly well-formed loads near the current time, ticks, and some noise.
   task automatic random_phase(input int n_words);
      int  roll;
      int  near;
      logic [BurstWidth-1:0] work;
      repeat (n_words) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            push_tick();
         end else if (roll < 88) begin
            if ($urandom_range(0, 4) == 0)
               near = $urandom_range(0, gen_time);
            else
               near = gen_time + $urandom_range(0, 24);
            if (near > 65535)
               near = 65535;
            if ($urandom_range(0, 9) == 0)
               work = BurstWidth'($urandom_range(0, 255));
            else
               work = BurstWidth'($urandom_range(1, 12));
            push_load(PnumWidth'($urandom_range(1, NumProc)), TimeWidth'(near), work);
         end else begin
            push_load(PnumWidth'($urandom_range(0, 31)),
                      TimeWidth'($urandom_range(0, 65535)),
                      BurstWidth'($urandom_range(0, 255)));
         end
      end
   endtask

   // Driver: feeds the backlog to the block, with random idle bursts.
   int    gap_left = 0;
   int    settle_cycles = 0;
   logic  gaps_on = 1'b1;

   always @(posedge clock) begin : driver_proc
      logic drive_item;
      logic drive_cfg;
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         settle_cycles = 0;
         slot_now = '0;
         count_reg = CountReset;
         for (int i = 0; i < NumProc; i++) begin
            proc_arrival[i] = '0;
            proc_left[i] = '0;
         end
      end else begin
         // Retire whatever was taken at this edge.
         if (start && !busy) begin
            schedule_word(word_backlog[0].word);
            word_backlog.pop_front();
            words_sent++;
            if (gaps_on && word_backlog.size() != 0 && word_backlog[0].gaps_ok &&
                $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 12);
            if ($urandom_range(0, 99) == 0)
               gaps_on = !gaps_on;
         end
         if (csr_valid && csr_ready) begin
            count_reg = word_backlog[0].count;
            word_backlog.pop_front();
            cfg_writes++;
         end

         // The count is only rewritten once the block has drained.
         if (due_reports.size() == 0 && !start)
            settle_cycles++;
         else
            settle_cycles = 0;

         drive_item = 1'b0;
         drive_cfg = 1'b0;
         if (word_backlog.size() != 0) begin
            if (word_backlog[0].is_cfg)
               drive_cfg = (settle_cycles >= SettleCycles);
            else if (gap_left != 0)
               gap_left--;
            else
               drive_item = 1'b1;
         end
         start <= drive_item;
         csr_valid <= drive_cfg;
         if (drive_item)
            req_data <= word_backlog[0].word;
         if (drive_cfg)
            csr_data <= word_backlog[0].count;
      end
   end

   // Field comparison for the monitor.
   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PrintLimit)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
      end
   endtask

   // Monitor: every strobed report is matched against the oldest expectation.
   always @(posedge clock) begin : monitor_proc
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= PrintLimit)
               $display("%0t ns: unexpected report, expected none, actual %h",
                        $time, rsp_data);
         end else begin
            want = due_reports.pop_front();
            compare_field("tick_time", want.tick_time, rsp_data.tick_time);
            compare_field("running_process", want.running_process,
                          rsp_data.running_process);
            compare_field("finished", want.finished, rsp_data.finished);
            compare_field("completion_time", want.completion_time,
                          rsp_data.completion_time);
            compare_field("all_done", want.all_done, rsp_data.all_done);
            reports_checked++;
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("%0t ns: no progress for %0d cycles, %0d words and %0d reports pending",
                  $time, StallLimit, word_backlog.size(), due_reports.size());
         $display("tb_top failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus plan and end of run.
   initial begin : stimulus_proc
      logic [PnumWidth-1:0] phase_count[NumPhases];
      int p;

      // Directed: fill every entry so no unwritten entry is ever scanned.
      push_load(5'd1, 16'd0, 8'd2);
      push_load(5'd2, 16'd6, 8'd3);
      push_load(5'd3, 16'd6, 8'd3);
      push_load(5'd4, 16'd7, 8'd1);
      push_load(5'd5, 16'd5, 8'd255);
      push_load(5'd6, 16'd0, 8'd0);
      push_load(5'd7, 16'hFFFF, 8'd0);
      for (p = 8; p <= 15; p++)
         push_load(PnumWidth'(p), TimeWidth'($urandom_range(0, 65535)), 8'd0);
      push_load(5'd16, 16'hFFFF, 8'd255);
      // Out-of-range load numbers are dropped.
      push_load(5'd0, 16'd0, 8'd1);
      push_load(5'd31, 16'd0, 8'd1);
      // Only the first entry is in use after reset; it finishes, then idles.
      push_tick();
      push_tick();
      push_tick();
      // With no entry in use every slot is idle and all done.
      push_cfg(5'd0);
      push_tick();
      // Full table: an idle gap before arrivals, then ties and preemption.
      push_cfg(5'd16);
      repeat (5)
         push_tick();

      // Random phases, each with its own process count.
      phase_count = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd5, 5'd16, 5'd2, 5'd9, 5'd16};
      phase_count[5] = PnumWidth'($urandom_range(0, 31));
      phase_count[8] = PnumWidth'($urandom_range(0, 31));
      for (p = 0; p < NumPhases; p++) begin
         push_cfg(phase_count[p]);
         random_phase(PhaseWords);
      end

      // Tail without idling: back-to-back words on the full table.
      gen_gaps = 1'b0;
      push_cfg(5'd16);
      random_phase(60);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (word_backlog.size() != 0 || due_reports.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d words and %0d count writes; checked %0d slot reports.",
               words_sent, cfg_writes, reports_checked);
      $display("Slots idle: %0d, completions: %0d, final slot %0d, mismatches: %0d.",
               idle_slots, finish_slots, slot_now, mismatches);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
